/* rtl/ple_pkg.sv */
package ple_pkg;

	// field widths of the command and result transfers
	localparam int unsigned CMD_W    = 3;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned POS_W    = 5;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 5;

	// index width broadcast to the cells, enough for the largest supported list
	localparam int unsigned CELL_IW = 6;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_INS_POS   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_POS   = 3'd5;
	localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BADPOS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL   = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic signed [VALUE_W-1:0] value;
		logic [POS_W-1:0]          position;
	} cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] element;
		logic [COUNT_W-1:0]        count;
		logic                      last;
	} result_t;

	// what every cell does in a cycle
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_ROT
	} cell_op_t;

	// control broadcast along the row
	typedef struct packed {
		cell_op_t                  op;
		logic [CELL_IW-1:0]        k;
		logic [CELL_IW-1:0]        tail;
		logic signed [VALUE_W-1:0] value;
	} cell_ctl_t;

endpackage

/* rtl/ple_chan_if.sv */
interface ple_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* rtl/ple_cell.sv */
module ple_cell #(
	parameter int unsigned IDX = 0
) (
	input  logic                               clk,
	input  ple_pkg::cell_ctl_t                 ctl,
	input  logic signed [ple_pkg::VALUE_W-1:0] left_val,
	input  logic signed [ple_pkg::VALUE_W-1:0] right_val,
	input  logic signed [ple_pkg::VALUE_W-1:0] head_val,
	output logic signed [ple_pkg::VALUE_W-1:0] val
);
	import ple_pkg::*;

	localparam logic [CELL_IW-1:0] ME = CELL_IW'(IDX);

	logic signed [VALUE_W-1:0] val_q;
	logic signed [VALUE_W-1:0] nxt;

	// pick the next content from the neighbours or the broadcast value
	always_comb begin
		nxt = val_q;
		unique case (ctl.op)
			CELL_INS: begin
				if (ME > ctl.k) begin
					nxt = left_val;
				end else if (ME == ctl.k) begin
					nxt = ctl.value;
				end
			end
			CELL_DEL: begin
				if (ME >= ctl.k && ME < ctl.tail) begin
					nxt = right_val;
				end
			end
			CELL_ROT: begin
				if (ME < ctl.tail) begin
					nxt = right_val;
				end else if (ME == ctl.tail) begin
					nxt = head_val;
				end
			end
			default: begin
				nxt = val_q;
			end
		endcase
	end

	// element storage, no reset needed
	always_ff @(posedge clk) begin
		val_q <= nxt;
	end

	assign val = val_q;

endmodule

/* rtl/positional_list_engine_top.sv */
// channel | dir | payload                                  | handshake
// req     | in  | command, value, position (ple_pkg::cmd_t)  | valid/ready, transfer on both high
// rsp     | out | status, element, count, last (result_t)    | valid/ready, transfer on both high
//
// On an insert or delete the cells from the target position onward take a neighbour's value.
// A dump enters the dump state, then hands out the elements in order as the row rotates past cell 0.
// The result sits in an output register; a new command is taken while it waits if it is taken.
// arst_n clears the count, the state and the result valid; cell contents need no reset.
// While a result is stalled downstream the row holds and no command is taken.
module positional_list_engine_top #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	ple_chan_if.sink   req,
	ple_chan_if.source rsp
);
	import ple_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = $clog2(CAPACITY);
	localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [IW-1:0]     idx_q;
	logic              rsp_valid_q;
	result_t           rsp_q;

	logic              slot_free;
	logic              accept;
	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     cnt_x;
	logic              is_empty;
	logic              is_full;
	logic [STATUS_W-1:0] cmd_status;
	logic [CW-1:0]     cmd_count;
	logic              dump_start;
	logic              dump_last;
	cell_ctl_t         ctl;

	logic signed [VALUE_W-1:0] vals [CAPACITY];

	// handshake
	assign slot_free = !rsp_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && slot_free;
	assign accept    = req.valid && req.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.payload = rsp_q;

	assign pos_x    = XW'(req.payload.position);
	assign cnt_x    = XW'(count_q);
	assign is_empty = (count_q == '0);
	assign is_full  = (cnt_x == XW'(CAPACITY));
	assign dump_last = ((XW'(idx_q) + XW'(1)) == cnt_x);

	// decode the command into a status, the new count and the row operation
	always_comb begin
		cmd_status = STAT_OK;
		cmd_count  = count_q;
		dump_start = 1'b0;
		ctl.op     = CELL_HOLD;
		ctl.k      = '0;
		ctl.tail   = CELL_IW'(cnt_x - XW'(1));
		ctl.value  = req.payload.value;
		if (state_q == S_DUMP) begin
			if (slot_free) begin
				ctl.op = CELL_ROT;
			end
		end else if (accept) begin
			unique case (req.payload.command)
				CMD_INS_FRONT, CMD_INS_BACK: begin
					if (is_full) begin
						cmd_status = STAT_FULL;
					end else begin
						ctl.op    = CELL_INS;
						ctl.k     = (req.payload.command == CMD_INS_FRONT) ? '0
							: CELL_IW'(cnt_x);
						cmd_count = count_q + CW'(1);
					end
				end
				CMD_INS_POS: begin
					if (pos_x == '0 || pos_x > (cnt_x + XW'(1))) begin
						cmd_status = STAT_BADPOS;
					end else if (is_full) begin
						cmd_status = STAT_FULL;
					end else begin
						ctl.op    = CELL_INS;
						ctl.k     = CELL_IW'(pos_x - XW'(1));
						cmd_count = count_q + CW'(1);
					end
				end
				CMD_DEL_FRONT, CMD_DEL_BACK: begin
					if (is_empty) begin
						cmd_status = STAT_EMPTY;
					end else begin
						ctl.op    = CELL_DEL;
						ctl.k     = (req.payload.command == CMD_DEL_FRONT) ? '0
							: CELL_IW'(cnt_x - XW'(1));
						cmd_count = count_q - CW'(1);
					end
				end
				CMD_DEL_POS: begin
					if (pos_x == '0 || pos_x > cnt_x) begin
						cmd_status = STAT_BADPOS;
					end else begin
						ctl.op    = CELL_DEL;
						ctl.k     = CELL_IW'(pos_x - XW'(1));
						cmd_count = count_q - CW'(1);
					end
				end
				CMD_DUMP: begin
					if (is_empty) begin
						cmd_status = STAT_EMPTY;
					end else begin
						dump_start = 1'b1;
					end
				end
				default: begin
					cmd_status = STAT_OK;
				end
			endcase
		end
	end

	// row of cells, each handing data to its neighbours
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] left_v;
		logic signed [VALUE_W-1:0] right_v;

		if (i == 0) begin : g_first
			assign left_v = ctl.value;
		end else begin : g_mid_l
			assign left_v = vals[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_v = vals[i];
		end else begin : g_mid_r
			assign right_v = vals[i+1];
		end

		ple_cell #(
			.IDX (i)
		) u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.left_val  (left_v),
			.right_val (right_v),
			.head_val  (vals[0]),
			.val       (vals[i])
		);
	end

	// control state, count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (state_q == S_DUMP) begin
				if (slot_free) begin
					rsp_valid_q    <= 1'b1;
					rsp_q.status   <= STAT_OK;
					rsp_q.element  <= vals[0];
					rsp_q.count    <= COUNT_W'(count_q);
					rsp_q.last     <= dump_last;
					idx_q          <= idx_q + IW'(1);
					if (dump_last) begin
						state_q <= S_IDLE;
					end
				end
			end else if (accept) begin
				count_q <= cmd_count;
				if (dump_start) begin
					state_q     <= S_DUMP;
					idx_q       <= '0;
					rsp_valid_q <= 1'b0;
				end else begin
					rsp_valid_q   <= 1'b1;
					rsp_q.status  <= cmd_status;
					rsp_q.element <= '0;
					rsp_q.count   <= COUNT_W'(cmd_count);
					rsp_q.last    <= 1'b1;
				end
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_x <= XW'(CAPACITY))
		else $error("list count beyond capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == $past(count_q)) || (count_q == $past(count_q) + CW'(1))
		|| (count_q == $past(count_q) - CW'(1)))
		else $error("list count moved by more than one");

	a_dump_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> !req.ready)
		else $error("command taken during dump");

	a_dump_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DUMP) |-> ((XW'(idx_q) < cnt_x) && !is_empty))
		else $error("dump index past the end of the list");

	a_single_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.payload.command != CMD_DUMP) |=> (rsp_valid_q && rsp_q.last))
		else $error("command without a final result");

endmodule
